@@ hw/rtl/wtm_pkg.sv @@
// Shared types, constants and wave-table helper functions of the wave-table modulator.
`default_nettype none

package wtm_pkg;

    localparam int TABLE_SIZE_DEF = 128;

    localparam int MODE_W   = 6;
    localparam int FREQ_W   = 16;
    localparam int PINIT_W  = 12;
    localparam int PRAND_W  = 17;
    localparam int DEPTH_W  = 32;
    localparam int CFG_DW   = 32;
    localparam int CFG_IW   = 3;
    localparam int AGE_W    = 16;
    localparam int RND_W    = 16;
    localparam int FACTOR_W = 17;
    localparam int WAVE_W   = 17;

    localparam logic [CFG_IW-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IW-1:0] REG_FREQ_X  = 3'd1;
    localparam logic [CFG_IW-1:0] REG_FREQ_Y  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_PINIT_X = 3'd3;
    localparam logic [CFG_IW-1:0] REG_PINIT_Y = 3'd4;
    localparam logic [CFG_IW-1:0] REG_PRAND_X = 3'd5;
    localparam logic [CFG_IW-1:0] REG_PRAND_Y = 3'd6;
    localparam logic [CFG_IW-1:0] REG_DEPTH   = 3'd7;

    localparam int MODE_SINE  = 0;
    localparam int MODE_SAW   = 1;
    localparam int MODE_RECT  = 2;
    localparam int MODE_ALPHA = 3;
    localparam int MODE_SCALE = 4;
    localparam int MODE_SEP_Y = 5;

    localparam logic [MODE_W-1:0]  MODE_RST  = '0;
    localparam logic [FREQ_W-1:0]  FREQ_RST  = 16'd256;
    localparam logic [PINIT_W-1:0] PINIT_RST = '0;
    localparam logic [PRAND_W-1:0] PRAND_RST = '0;
    localparam logic [DEPTH_W-1:0] DEPTH_RST = 32'h4000_4000;

    localparam logic signed [FACTOR_W-1:0] FACTOR_ONE = 17'sd16384;
    localparam logic [WAVE_W-1:0]          WAVE_FULL  = 17'd65536;

    // Index arithmetic widths: sum of age and start phase, the two products,
    // and the integer phase before reduction to a table index.
    localparam int SUM_W = 17;
    localparam int PRD_W = 33;
    localparam int QUO_W = 26;
    localparam int DIG_W = 2;

    localparam longint          ONE_Q30     = 64'sd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic signed [FACTOR_W-1:0] t_factor;
    typedef logic [WAVE_W-1:0]          t_wave;

    function automatic longint taylor_cos(input longint unsigned t);
        longint unsigned t2;
        longint unsigned term;
        longint          sum;
        t2   = (t * t) >> 30;
        term = 64'd1073741824;
        sum  = ONE_Q30;
        term = ((term * t2) >> 30) / 2;
        sum  = sum - longint'(term);
        term = ((term * t2) >> 30) / 12;
        sum  = sum + longint'(term);
        term = ((term * t2) >> 30) / 30;
        sum  = sum - longint'(term);
        term = ((term * t2) >> 30) / 56;
        sum  = sum + longint'(term);
        term = ((term * t2) >> 30) / 90;
        sum  = sum - longint'(term);
        term = ((term * t2) >> 30) / 132;
        sum  = sum + longint'(term);
        return sum;
    endfunction

    function automatic longint taylor_sin(input longint unsigned t);
        longint unsigned t2;
        longint unsigned term;
        longint          sum;
        t2   = (t * t) >> 30;
        term = t;
        sum  = longint'(t);
        term = ((term * t2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * t2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * t2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * t2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * t2) >> 30) / 110;
        sum  = sum - longint'(term);
        term = ((term * t2) >> 30) / 156;
        sum  = sum + longint'(term);
        return sum;
    endfunction

    // Raised cosine in unsigned Q1.16 from the quadrant and the reduced cosine and sine.
    function automatic t_wave sine_wave(input logic [1:0] quad, input longint cu,
                                        input longint su);
        longint c;
        longint v;
        case (quad)
            2'd0:    c = cu;
            2'd1:    c = -su;
            2'd2:    c = -cu;
            default: c = su;
        endcase
        v = c + ONE_Q30;
        if (v < 0) begin
            v = 0;
        end
        return WAVE_W'((v + 64'sd16384) >>> 15);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/wtm_in_if.sv @@
// Input channel carrying one particle per transfer.
`default_nettype none

interface wtm_in_if
    import wtm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [AGE_W-1:0] particle_age;
    logic [RND_W-1:0] particle_random;

    modport source (output valid, output particle_age, output particle_random, input ready);
    modport sink (input valid, input particle_age, input particle_random, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/wtm_out_if.sv @@
// Output channel carrying one set of modulation factors per transfer.
`default_nettype none

interface wtm_out_if
    import wtm_pkg::*;
();
    logic    valid;
    logic    ready;
    t_factor alpha_factor;
    logic    alpha_valid;
    t_factor scale_x_factor;
    t_factor scale_y_factor;
    logic    scale_valid;

    modport source (output valid, output alpha_factor, output alpha_valid,
                    output scale_x_factor, output scale_y_factor, output scale_valid,
                    input ready);
    modport sink (input valid, input alpha_factor, input alpha_valid,
                  input scale_x_factor, input scale_y_factor, input scale_valid,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/wave_table_modulator.sv @@
// Top level of the wave-table modulator: config registers and the factor pipeline.
//
// Each particle transfer on i_item yields exactly one transfer on o_result, in order.
// The block takes one particle per clock while its input is not blocked by back-pressure.
// Its stages form the phase products and their sum, reduce the integer phase modulo
// TABLE_SIZE (two quotient bits per stage), then do the wave lookup, the depth
// product and the output register. Every stage holds its item under back-pressure,
// and bubbles close up, so a stalled output only blocks the input once all stages
// are full. Configuration must be written while idle.
`default_nettype none

module wave_table_modulator
    import wtm_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  [CFG_IW-1:0]   i_cfg_idx,
    input  wire  [CFG_DW-1:0]   i_cfg_data,
    wtm_in_if.sink              i_item,
    wtm_out_if.source           o_result
);

    localparam int IW      = $clog2(TABLE_SIZE);
    localparam int BW      = PRD_W + $clog2(TABLE_SIZE + 1);
    localparam int SW      = BW + 1;
    localparam int CW      = SW - 32;
    localparam int MOD_STG = QUO_W / DIG_W;
    localparam int ST_MOD  = 3;
    localparam int ST_WAVE = ST_MOD + MOD_STG;
    localparam int ST_PROD = ST_WAVE + 1;
    localparam int ST_OUT  = ST_PROD + 1;
    localparam int NS      = ST_OUT + 1;

    localparam logic [IW+1:0] N1 = (IW+2)'(TABLE_SIZE);
    localparam logic [IW+1:0] N2 = (IW+2)'(2 * TABLE_SIZE);
    localparam logic [IW+1:0] N3 = (IW+2)'(3 * TABLE_SIZE);
    localparam logic [IW:0]   NH = (IW+1)'(TABLE_SIZE / 2);

    // Constant wave tables.
    t_wave sine_rom [TABLE_SIZE];
    t_wave saw_rom  [TABLE_SIZE];

    for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_rom
        localparam longint unsigned QD = (4 * gi) / TABLE_SIZE;
        localparam longint unsigned RR = 4 * gi - QD * TABLE_SIZE;
        localparam bit              LO = (2 * RR <= TABLE_SIZE);
        localparam longint unsigned RA = LO ? RR : TABLE_SIZE - RR;
        localparam longint unsigned TA = (HALF_PI_Q30 * RA + TABLE_SIZE / 2) / TABLE_SIZE;
        localparam longint          CU = LO ? taylor_cos(TA) : taylor_sin(TA);
        localparam longint          SU = LO ? taylor_sin(TA) : taylor_cos(TA);
        localparam t_wave           SV = sine_wave(QD[1:0], CU, SU);
        localparam t_wave           WV = WAVE_W'((longint'(gi) * 131072 + TABLE_SIZE)
                                                 / (2 * TABLE_SIZE));
        assign sine_rom[gi] = SV;
        assign saw_rom[gi]  = WV;
    end

    // Configuration registers.
    logic [MODE_W-1:0]  r_mode;
    logic [FREQ_W-1:0]  r_freq  [2];
    logic [PINIT_W-1:0] r_pinit [2];
    logic [PRAND_W-1:0] r_prand [2];
    logic [DEPTH_W-1:0] r_depth;
    logic [15:0]        depth_ch [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_RST;
            r_freq[0]  <= FREQ_RST;
            r_freq[1]  <= FREQ_RST;
            r_pinit[0] <= PINIT_RST;
            r_pinit[1] <= PINIT_RST;
            r_prand[0] <= PRAND_RST;
            r_prand[1] <= PRAND_RST;
            r_depth    <= DEPTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:    r_mode     <= i_cfg_data[MODE_W-1:0];
                REG_FREQ_X:  r_freq[0]  <= i_cfg_data[FREQ_W-1:0];
                REG_FREQ_Y:  r_freq[1]  <= i_cfg_data[FREQ_W-1:0];
                REG_PINIT_X: r_pinit[0] <= i_cfg_data[PINIT_W-1:0];
                REG_PINIT_Y: r_pinit[1] <= i_cfg_data[PINIT_W-1:0];
                REG_PRAND_X: r_prand[0] <= i_cfg_data[PRAND_W-1:0];
                REG_PRAND_Y: r_prand[1] <= i_cfg_data[PRAND_W-1:0];
                REG_DEPTH:   r_depth    <= i_cfg_data[DEPTH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign depth_ch[0] = r_depth[15:0];
    assign depth_ch[1] = r_depth[31:16];

    // Stage valid bits and per-stage advance.
    logic [NS-1:0] r_vld;
    logic [NS-1:0] rdy;

    always_comb begin
        rdy[NS-1] = !r_vld[NS-1] || o_result.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_item.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_item.ready = rdy[0];

    // Datapath registers, one set per channel (x, y).
    logic [PRD_W-1:0] r_p    [2];
    logic [PRD_W-1:0] r_r    [2];
    logic [PRD_W-1:0] r_p1   [2];
    logic [BW-1:0]    r_b    [2];
    logic [QUO_W-1:0] r_q    [2];
    logic [IW-1:0]    r_rem  [MOD_STG][2];
    logic [QUO_W-1:0] r_qm   [MOD_STG][2];
    t_wave            r_wave [2];
    logic [PRD_W-1:0] r_prod [2];

    logic [PRD_W-1:0] n_p    [2];
    logic [PRD_W-1:0] n_r    [2];
    logic [QUO_W-1:0] n_q    [2];
    logic [IW-1:0]    n_rem  [MOD_STG][2];
    t_wave            n_wave [2];
    t_factor          fac    [2];

    always_comb begin
        logic [SUM_W-1:0]  sum_pa;
        logic [SW-1:0]     low_sum;
        logic [CW-1:0]     carry_int;
        logic [IW+1:0]     part;
        logic [IW-1:0]     rem_in;
        logic [QUO_W-1:0]  q_in;
        logic [IW:0]       idx;
        logic [PRD_W:0]    rnd_prod;
        for (int ch = 0; ch < 2; ch++) begin
            sum_pa    = SUM_W'(i_item.particle_age) + SUM_W'(r_pinit[ch]);
            n_p[ch]   = PRD_W'(sum_pa) * PRD_W'(r_freq[ch]);
            n_r[ch]   = PRD_W'(i_item.particle_random) * PRD_W'(r_prand[ch]);
            low_sum   = SW'({r_p1[ch][7:0], 24'b0}) + SW'(r_b[ch]);
            carry_int = low_sum[SW-1:32];
            n_q[ch]   = QUO_W'(r_p1[ch][PRD_W-1:8]) + QUO_W'(carry_int);
            for (int m = 0; m < MOD_STG; m++) begin
                rem_in = (m == 0) ? '0 : r_rem[(m == 0) ? 0 : m - 1][ch];
                q_in   = (m == 0) ? r_q[ch] : r_qm[(m == 0) ? 0 : m - 1][ch];
                part   = {rem_in, q_in[QUO_W - 1 - DIG_W * m -: DIG_W]};
                if (part >= N3) begin
                    part = part - N3;
                end else if (part >= N2) begin
                    part = part - N2;
                end else if (part >= N1) begin
                    part = part - N1;
                end
                n_rem[m][ch] = part[IW-1:0];
            end
            idx = {1'b0, r_rem[MOD_STG-1][ch]};
            if (r_mode[MODE_RECT]) begin
                n_wave[ch] = (idx < NH) ? WAVE_FULL : '0;
            end else if (r_mode[MODE_SAW]) begin
                n_wave[ch] = saw_rom[r_rem[MOD_STG-1][ch]];
            end else if (r_mode[MODE_SINE]) begin
                n_wave[ch] = sine_rom[r_rem[MOD_STG-1][ch]];
            end else begin
                n_wave[ch] = '0;
            end
            rnd_prod = (PRD_W+1)'(r_prod[ch]) + (PRD_W+1)'(32768);
            fac[ch]  = FACTOR_ONE - FACTOR_W'(rnd_prod[PRD_W:16]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < 2; ch++) begin
            if (rdy[0]) begin
                r_p[ch] <= n_p[ch];
                r_r[ch] <= n_r[ch];
            end
            if (rdy[1]) begin
                r_p1[ch] <= r_p[ch];
                r_b[ch]  <= BW'(r_r[ch]) * BW'(TABLE_SIZE);
            end
            if (rdy[2]) begin
                r_q[ch] <= n_q[ch];
            end
            for (int m = 0; m < MOD_STG; m++) begin
                if (rdy[ST_MOD + m]) begin
                    r_rem[m][ch] <= n_rem[m][ch];
                    r_qm[m][ch]  <= (m == 0) ? r_q[ch] : r_qm[(m == 0) ? 0 : m - 1][ch];
                end
            end
            if (rdy[ST_WAVE]) begin
                r_wave[ch] <= n_wave[ch];
            end
            if (rdy[ST_PROD]) begin
                r_prod[ch] <= PRD_W'(r_wave[ch]) * PRD_W'(depth_ch[ch]);
            end
        end
    end

    // Output register.
    t_factor r_alpha;
    logic    r_alpha_vld;
    t_factor r_scale_x;
    t_factor r_scale_y;
    logic    r_scale_vld;

    always_ff @(posedge i_clk) begin
        if (rdy[ST_OUT]) begin
            r_alpha     <= r_mode[MODE_ALPHA] ? fac[0] : FACTOR_ONE;
            r_alpha_vld <= r_mode[MODE_ALPHA];
            r_scale_x   <= r_mode[MODE_SCALE] ? fac[0] : FACTOR_ONE;
            r_scale_y   <= !r_mode[MODE_SCALE] ? FACTOR_ONE :
                           (r_mode[MODE_SEP_Y] ? fac[1] : fac[0]);
            r_scale_vld <= r_mode[MODE_SCALE];
        end
    end

    assign o_result.valid          = r_vld[NS-1];
    assign o_result.alpha_factor   = r_alpha;
    assign o_result.alpha_valid    = r_alpha_vld;
    assign o_result.scale_x_factor = r_scale_x;
    assign o_result.scale_y_factor = r_scale_y;
    assign o_result.scale_valid    = r_scale_vld;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_WAVE-1] |->
            ({1'b0, r_rem[MOD_STG-1][0]} < (IW+1)'(TABLE_SIZE)) &&
            ({1'b0, r_rem[MOD_STG-1][1]} < (IW+1)'(TABLE_SIZE)))
        else $error("Reduced table index is not below the table size.");

    a_empty_out_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NS-1] |-> i_item.ready)
        else $error("Input is stalled although the output stage is empty.");

    a_alpha_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.alpha_valid) |-> (o_result.alpha_factor == FACTOR_ONE))
        else $error("Alpha factor is not unity while alpha is off.");

    a_scale_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.scale_valid) |->
            (o_result.scale_x_factor == FACTOR_ONE) && (o_result.scale_y_factor == FACTOR_ONE))
        else $error("Scale factors are not unity while scale is off.");

    a_factor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.scale_x_factor >= -17'sd49151) &&
                           (o_result.scale_y_factor >= -17'sd49151))
        else $error("Scale factor below the lowest reachable value.");

endmodule

`default_nettype wire

@@ test/wtm_factor_checker.sv @@
// Checker that mirrors the modulator registers, predicts every factor set and compares it.
`timescale 1ns / 1ps

module wtm_factor_checker
    import wtm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    wtm_in_if                 i_item,
    wtm_out_if                i_result,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);

    localparam int              TBL              = TABLE_SIZE_DEF;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam longint unsigned UNIT_Q30         = 64'd1073741824;

    typedef struct packed {
        t_factor alpha_factor;
        logic    alpha_valid;
        t_factor scale_x_factor;
        t_factor scale_y_factor;
        logic    scale_valid;
    } factor_set_t;

    logic [MODE_W-1:0]  cur_mode;
    logic [FREQ_W-1:0]  cur_freq_x;
    logic [FREQ_W-1:0]  cur_freq_y;
    logic [PINIT_W-1:0] cur_pinit_x;
    logic [PINIT_W-1:0] cur_pinit_y;
    logic [PRAND_W-1:0] cur_prand_x;
    logic [PRAND_W-1:0] cur_prand_y;
    logic [DEPTH_W-1:0] cur_depth;

    factor_set_t expected_factors[$];
    factor_set_t due;
    int          fails;
    int          checked;

    // Truncated power series of cosine (odd = 0) or sine (odd = 1) in Q30.
    function automatic longint power_series(input longint unsigned t, input bit odd);
        longint unsigned t2;
        longint unsigned term;
        longint unsigned base;
        longint          acc;
        t2   = (t * t) >> 30;
        term = odd ? t : UNIT_Q30;
        acc  = longint'(term);
        for (int k = 1; k <= 6; k++) begin
            base = 2 * k - 1 + odd;
            term = ((term * t2) >> 30) / (base * (base + 1));
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        return acc;
    endfunction

    function automatic longint unsigned raised_cosine(input int unsigned idx);
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned ang;
        longint          cu;
        longint          su;
        longint          c;
        quad = (4 * longint'(idx)) / TBL;
        rem  = 4 * longint'(idx) - quad * TBL;
        if (2 * rem <= TBL) begin
            ang = (QUARTER_TURN_Q30 * rem + TBL / 2) / TBL;
            cu  = power_series(ang, 1'b0);
            su  = power_series(ang, 1'b1);
        end else begin
            ang = (QUARTER_TURN_Q30 * (TBL - rem) + TBL / 2) / TBL;
            cu  = power_series(ang, 1'b1);
            su  = power_series(ang, 1'b0);
        end
        case (quad[1:0])
            2'd0:    c = cu;
            2'd1:    c = -su;
            2'd2:    c = -cu;
            default: c = su;
        endcase
        c = c + longint'(UNIT_Q30);
        if (c < 0) begin
            c = 0;
        end
        return longint'((c + 16384) >>> 15);
    endfunction

    function automatic t_factor sampled_factor(input logic [AGE_W-1:0] age,
                                               input logic [RND_W-1:0] rnd,
                                               input logic [FREQ_W-1:0] freq,
                                               input logic [PINIT_W-1:0] pinit,
                                               input logic [PRAND_W-1:0] prand,
                                               input logic [15:0] depth);
        longint unsigned phase_q32;
        longint unsigned spread_q32;
        longint unsigned wave;
        int unsigned     idx;
        phase_q32  = ((longint'(age) + longint'(pinit)) * longint'(freq)) << 24;
        spread_q32 = longint'(TBL) * longint'(rnd) * longint'(prand);
        idx        = int'(((phase_q32 + spread_q32) >> 32) % TBL);
        if (cur_mode[MODE_RECT]) begin
            wave = (idx < TBL / 2) ? 65536 : 0;
        end else if (cur_mode[MODE_SAW]) begin
            wave = (longint'(idx) * 131072 + TBL) / (2 * TBL);
        end else if (cur_mode[MODE_SINE]) begin
            wave = raised_cosine(idx);
        end else begin
            return FACTOR_ONE;
        end
        return t_factor'(longint'(FACTOR_ONE) - longint'((wave * depth + 32768) >> 16));
    endfunction

    function automatic factor_set_t predict_factors(input logic [AGE_W-1:0] age,
                                                    input logic [RND_W-1:0] rnd);
        factor_set_t f;
        t_factor     fx;
        t_factor     fy;
        fx = sampled_factor(age, rnd, cur_freq_x, cur_pinit_x, cur_prand_x, cur_depth[15:0]);
        fy = fx;
        if (cur_mode[MODE_SEP_Y]) begin
            fy = sampled_factor(age, rnd, cur_freq_y, cur_pinit_y, cur_prand_y,
                                cur_depth[31:16]);
        end
        f.alpha_valid    = cur_mode[MODE_ALPHA];
        f.alpha_factor   = f.alpha_valid ? fx : FACTOR_ONE;
        f.scale_valid    = cur_mode[MODE_SCALE];
        f.scale_x_factor = f.scale_valid ? fx : FACTOR_ONE;
        f.scale_y_factor = f.scale_valid ? fy : FACTOR_ONE;
        return f;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_mode    = MODE_RST;
            cur_freq_x  = FREQ_RST;
            cur_freq_y  = FREQ_RST;
            cur_pinit_x = PINIT_RST;
            cur_pinit_y = PINIT_RST;
            cur_prand_x = PRAND_RST;
            cur_prand_y = PRAND_RST;
            cur_depth   = DEPTH_RST;
            expected_factors.delete();
            fails   = 0;
            checked = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MODE:    cur_mode    = i_cfg_data[MODE_W-1:0];
                    REG_FREQ_X:  cur_freq_x  = i_cfg_data[FREQ_W-1:0];
                    REG_FREQ_Y:  cur_freq_y  = i_cfg_data[FREQ_W-1:0];
                    REG_PINIT_X: cur_pinit_x = i_cfg_data[PINIT_W-1:0];
                    REG_PINIT_Y: cur_pinit_y = i_cfg_data[PINIT_W-1:0];
                    REG_PRAND_X: cur_prand_x = i_cfg_data[PRAND_W-1:0];
                    REG_PRAND_Y: cur_prand_y = i_cfg_data[PRAND_W-1:0];
                    REG_DEPTH:   cur_depth   = i_cfg_data[DEPTH_W-1:0];
                endcase
            end
            if (i_result.valid && i_result.ready) begin
                if (expected_factors.size() == 0) begin
                    $error("Factor transfer arrived with no particle outstanding");
                    fails++;
                end else begin
                    due = expected_factors.pop_front();
                    checked++;
                    if (i_result.alpha_factor !== due.alpha_factor) begin
                        $error("alpha_factor mismatch: expected %0d, got %0d",
                               due.alpha_factor, i_result.alpha_factor);
                        fails++;
                    end
                    if (i_result.alpha_valid !== due.alpha_valid) begin
                        $error("alpha_valid mismatch: expected %0d, got %0d",
                               due.alpha_valid, i_result.alpha_valid);
                        fails++;
                    end
                    if (i_result.scale_x_factor !== due.scale_x_factor) begin
                        $error("scale_x_factor mismatch: expected %0d, got %0d",
                               due.scale_x_factor, i_result.scale_x_factor);
                        fails++;
                    end
                    if (i_result.scale_y_factor !== due.scale_y_factor) begin
                        $error("scale_y_factor mismatch: expected %0d, got %0d",
                               due.scale_y_factor, i_result.scale_y_factor);
                        fails++;
                    end
                    if (i_result.scale_valid !== due.scale_valid) begin
                        $error("scale_valid mismatch: expected %0d, got %0d",
                               due.scale_valid, i_result.scale_valid);
                        fails++;
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                expected_factors.push_back(predict_factors(i_item.particle_age,
                                                           i_item.particle_random));
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_factors.size();
        o_checked    <= checked;
    end

endmodule

@@ test/tb_wave_table_modulator.sv @@
// Top-level testbench of the wave-table modulator: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_wave_table_modulator;
    import wtm_pkg::*;

    localparam int LATENCY        = 19;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 70;

    localparam logic [MODE_W-1:0] SINE_ON  = MODE_W'(1 << MODE_SINE);
    localparam logic [MODE_W-1:0] SAW_ON   = MODE_W'(1 << MODE_SAW);
    localparam logic [MODE_W-1:0] RECT_ON  = MODE_W'(1 << MODE_RECT);
    localparam logic [MODE_W-1:0] ALPHA_ON = MODE_W'(1 << MODE_ALPHA);
    localparam logic [MODE_W-1:0] SCALE_ON = MODE_W'(1 << MODE_SCALE);
    localparam logic [MODE_W-1:0] SEP_Y_ON = MODE_W'(1 << MODE_SEP_Y);

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [FREQ_W-1:0]  freq_x;
        logic [FREQ_W-1:0]  freq_y;
        logic [PINIT_W-1:0] pinit_x;
        logic [PINIT_W-1:0] pinit_y;
        logic [PRAND_W-1:0] prand_x;
        logic [PRAND_W-1:0] prand_y;
        logic [DEPTH_W-1:0] depth;
    } reg_setting_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              cfg_we   = 1'b0;
    logic [CFG_IW-1:0] cfg_idx  = '0;
    logic [CFG_DW-1:0] cfg_data = '0;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    bit hold_req       = 1'b0;
    int particles_sent = 0;
    int settings_used  = 0;
    int fail_count;
    int factors_pending;
    int factors_checked;

    wtm_in_if  item_if ();
    wtm_out_if result_if ();

    wave_table_modulator i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (item_if),
        .o_result   (result_if)
    );

    wtm_factor_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_item       (item_if),
        .i_result     (result_if),
        .o_fail_count (fail_count),
        .o_pending    (factors_pending),
        .o_checked    (factors_checked)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned biased(input int unsigned top);
        case ($urandom_range(15))
            0:       return 0;
            1:       return top;
            2:       return $urandom_range(0, 15);
            default: return $urandom_range(0, top);
        endcase
    endfunction

    function automatic reg_setting_t make_setting(input logic [MODE_W-1:0] mode,
                                                  input logic [FREQ_W-1:0] freq_x,
                                                  input logic [FREQ_W-1:0] freq_y,
                                                  input logic [PINIT_W-1:0] pinit_x,
                                                  input logic [PINIT_W-1:0] pinit_y,
                                                  input logic [PRAND_W-1:0] prand_x,
                                                  input logic [PRAND_W-1:0] prand_y,
                                                  input logic [DEPTH_W-1:0] depth);
        reg_setting_t s;
        s.mode    = mode;
        s.freq_x  = freq_x;
        s.freq_y  = freq_y;
        s.pinit_x = pinit_x;
        s.pinit_y = pinit_y;
        s.prand_x = prand_x;
        s.prand_y = prand_y;
        s.depth   = depth;
        return s;
    endfunction

    function automatic reg_setting_t random_setting();
        logic [MODE_W-1:0]  mode;
        logic [PRAND_W-1:0] rx;
        mode = MODE_W'($urandom);
        if ($urandom_range(3) != 0) begin
            mode = mode | SCALE_ON;
        end
        rx = PRAND_W'(biased(131071));
        if ($urandom_range(5) == 0) begin
            rx = 17'd65536;
        end
        return make_setting(mode, FREQ_W'(biased(65535)), FREQ_W'(biased(65535)),
                            PINIT_W'(biased(4095)), PINIT_W'(biased(4095)),
                            rx, PRAND_W'(biased(131071)),
                            {16'(biased(65535)), 16'(biased(65535))});
    endfunction

    // Bits above the register width carry noise, which the block must drop.
    function automatic logic [CFG_DW-1:0] with_stray_bits(input logic [CFG_DW-1:0] value,
                                                          input int width);
        if (width >= CFG_DW) begin
            return value;
        end
        return value | (CFG_DW'($urandom) << width);
    endfunction

    task automatic settle();
        item_if.valid <= 1'b0;
        do @(posedge clk); while (factors_pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic apply_setting(input reg_setting_t s);
        settle();
        write_reg(REG_MODE, with_stray_bits(CFG_DW'(s.mode), MODE_W));
        write_reg(REG_FREQ_X, with_stray_bits(CFG_DW'(s.freq_x), FREQ_W));
        write_reg(REG_FREQ_Y, with_stray_bits(CFG_DW'(s.freq_y), FREQ_W));
        write_reg(REG_PINIT_X, with_stray_bits(CFG_DW'(s.pinit_x), PINIT_W));
        write_reg(REG_PINIT_Y, with_stray_bits(CFG_DW'(s.pinit_y), PINIT_W));
        write_reg(REG_PRAND_X, with_stray_bits(CFG_DW'(s.prand_x), PRAND_W));
        write_reg(REG_PRAND_Y, with_stray_bits(CFG_DW'(s.prand_y), PRAND_W));
        write_reg(REG_DEPTH, with_stray_bits(CFG_DW'(s.depth), DEPTH_W));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_item(input logic [AGE_W-1:0] age, input logic [RND_W-1:0] rnd);
        while ($urandom_range(99) < src_idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid           <= 1'b1;
        item_if.particle_age    <= age;
        item_if.particle_random <= rnd;
        do @(posedge clk); while (!(item_if.valid && item_if.ready));
        particles_sent++;
    endtask

    initial begin : sink_driver
        result_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                result_if.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        item_if.valid           = 1'b0;
        item_if.particle_age    = '0;
        item_if.particle_random = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Registers still at their reset values: no waveform selected.
        send_item(16'h0000, 16'h0000);
        send_item(16'hFFFF, 16'hFFFF);

        // Sine at full depth across quadrant and octant boundaries.
        apply_setting(make_setting(SINE_ON | ALPHA_ON | SCALE_ON, 16'd256, 16'd256,
                                   12'd0, 12'd0, 17'd0, 17'd0, 32'hFFFF_FFFF));
        for (int k = 0; k < 6; k++) begin
            send_item(AGE_W'(k * 16), '0);
        end

        // Saw wins over sine; the y channel has zero frequency and a full-period spread.
        apply_setting(make_setting(SINE_ON | SAW_ON | ALPHA_ON | SCALE_ON | SEP_Y_ON,
                                   16'hFFFF, 16'd0, 12'd4095, 12'd0, 17'd0, 17'd65536,
                                   32'h0000_FFFF));
        send_item(16'hFFFF, 16'hFFFF);
        send_item(16'h0000, 16'h0000);
        send_item(16'h0001, 16'h8000);

        // Rectangle wins over everything; the x spread exceeds one period.
        apply_setting(make_setting(6'h3F, 16'd128, 16'hFFFF, 12'd0, 12'd4095,
                                   17'h1FFFF, 17'd1, 32'hFFFF_0000));
        send_item(16'h0000, 16'hFFFF);
        send_item(16'hFFFF, 16'h0000);
        send_item(16'd63, 16'd1234);
        send_item(16'd64, 16'd0);

        // Waves selected but neither alpha nor scale applied.
        apply_setting(make_setting(SINE_ON | SAW_ON | RECT_ON | SEP_Y_ON, 16'd256, 16'd256,
                                   12'd0, 12'd0, 17'd65536, 17'd65536, 32'hFFFF_FFFF));
        send_item(16'd5, 16'hFFFF);
        send_item(16'd100, 16'h0000);

        // Both factors applied with no waveform selected.
        apply_setting(make_setting(ALPHA_ON | SCALE_ON | SEP_Y_ON, 16'hFFFF, 16'hFFFF,
                                   12'd4095, 12'd4095, 17'h1FFFF, 17'h1FFFF, 32'hFFFF_FFFF));
        send_item(16'hFFFF, 16'hFFFF);
        send_item(16'h0000, 16'h0000);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            apply_setting(random_setting());
            case (p % 4)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 82;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 82;
                end
                default: begin
                    src_idle_pct   = 20;
                    sink_stall_pct = 20;
                end
            endcase
            if (p == 0) begin
                hold_req = 1'b1;
            end
            repeat (PHASE_ITEMS) begin
                send_item(AGE_W'(biased(65535)), RND_W'(biased(65535)));
            end
        end

        settle();
        repeat (LATENCY + 10) @(posedge clk);
        $display("Covered %0d particles under %0d register settings; %0d factor sets checked.",
                 particles_sent, settings_used, factors_checked);
        $display("Flow control included a %0d-cycle output hold-off, sender gaps and stalls.",
                 HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
